// ===== rtl/core/olarm_pkg.sv =====
package olarm_pkg;

    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Item operation codes.
    localparam logic ACT_APPEND = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_APPENDED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    // Strobes broadcast from the controller to every cell of the row.
    typedef struct packed {
        logic cmp_en;
        logic app_en;
        logic rem_en;
    } cell_ctrl_t;

endpackage

// ===== rtl/core/ordered_list_append_remove_match.sv =====
// Channel | Direction | Handshake            | Fields
// --------+-----------+----------------------+----------------------------
// in      | input     | in_valid / in_stall  | action, item_value
// out     | output    | out_valid / out_stall| status, entry_count
//
// Each item passes through S_IDLE, where the beat is accepted and every
// cell compares its entry with the value at that edge, and S_APPLY, where
// the row appends or closes the gap while the result goes into the output
// register. The apply step waits while a previous result is stalled.
// rst_n clears the count, the controller and the output valid; entries
// need no clearing since only places below the count are ever read.
//
// The list lives in a row of CAPACITY cells, one entry per cell, oldest in
// cell 0. A remove finds the first match through a seen flag that passes
// from each cell to its right neighbor; every cell at or after the first
// match takes the value of its right neighbor, which shifts the tail left
// by one place in a single step. An append writes the cell whose index
// equals the current count.
module ordered_list_append_remove_match
    import olarm_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     action,
    input  logic signed [DATA_W-1:0] item_value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [STATUS_W-1:0]      status,
    output logic [COUNT_W-1:0]       entry_count
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    typedef enum logic
    {
        S_IDLE,
        S_APPLY
    } state_t;

    state_t                   state_reg;
    logic                     action_reg;
    logic signed [DATA_W-1:0] key_reg;
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic                     out_valid_reg;
    logic [STATUS_W-1:0]      status_reg;
    logic [STATUS_W-1:0]      status_next;
    logic [COUNT_W-1:0]       entry_count_reg;
    logic [CW+COUNT_W-1:0]    count_wide;

    logic                     in_accept;
    logic                     out_free;
    logic                     apply;
    logic                     found;
    cell_ctrl_t               ctrl;
    logic signed [DATA_W-1:0] cell_key;

    logic signed [DATA_W-1:0] cell_value [CAPACITY+1];
    logic                     cell_seen  [CAPACITY+1];

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign apply     = (state_reg == S_APPLY) && out_free;

    // During the accept edge the cells compare against the incoming value;
    // afterwards they see the held value for an append.
    assign cell_key = (state_reg == S_IDLE) ? item_value : key_reg;

    assign ctrl.cmp_en = in_accept;
    assign ctrl.app_en = apply && (action_reg == ACT_APPEND) && (count_reg != CAP);
    assign ctrl.rem_en = apply && (action_reg == ACT_REMOVE);

    assign cell_seen[0]         = 1'b0;
    assign cell_value[CAPACITY] = '0;
    assign found                = cell_seen[CAPACITY];

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            olarm_cell #(
                .INDEX (gi),
                .CW    (CW)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .count       (count_reg),
                .key         (cell_key),
                .right_value (cell_value[gi+1]),
                .seen_in     (cell_seen[gi]),
                .value       (cell_value[gi]),
                .seen_out    (cell_seen[gi+1])
            );
        end
    endgenerate

    always_comb
    begin
        count_next  = count_reg;
        status_next = ST_NOT_FOUND;
        if (action_reg == ACT_APPEND)
        begin
            if (count_reg == CAP)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                status_next = ST_APPENDED;
                count_next  = count_reg + CW'(1);
            end
        end
        else if (found)
        begin
            status_next = ST_REMOVED;
            count_next  = count_reg - CW'(1);
        end
    end

    // The reported count is the occupancy masked to the field width.
    assign count_wide = {{COUNT_W{1'b0}}, count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
            action_reg      <= ACT_APPEND;
            key_reg         <= '0;
            status_reg      <= ST_APPENDED;
            entry_count_reg <= '0;
        end
        else
        begin
            // A new result takes the output register; otherwise an accepted
            // result leaves it empty.
            if (apply)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        action_reg <= action;
                        key_reg    <= item_value;
                        state_reg  <= S_APPLY;
                    end
                end
                S_APPLY:
                begin
                    if (out_free)
                    begin
                        count_reg       <= count_next;
                        status_reg      <= status_next;
                        entry_count_reg <= count_wide[COUNT_W-1:0];
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign entry_count = entry_count_reg;

endmodule

// ===== rtl/core/olarm_cell.sv =====
module olarm_cell
    import olarm_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CW    = 5
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cell_ctrl_t               ctrl,
    input  logic [CW-1:0]            count,
    input  logic signed [DATA_W-1:0] key,
    input  logic signed [DATA_W-1:0] right_value,
    input  logic                     seen_in,
    output logic signed [DATA_W-1:0] value,
    output logic                     seen_out
);

    localparam logic [CW-1:0] IDX = CW'(INDEX);

    logic signed [DATA_W-1:0] value_reg;
    logic                     match_reg;

    // A match at this place or any earlier one means this cell takes its
    // right neighbor's value when a remove is applied.
    assign seen_out = seen_in | match_reg;
    assign value    = value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (ctrl.cmp_en)
        begin
            match_reg <= (IDX < count) && (value_reg == key);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.app_en && (IDX == count))
        begin
            value_reg <= key;
        end
        else if (ctrl.rem_en && seen_out)
        begin
            value_reg <= right_value;
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

// Testbench for the ordered list block. Append and remove beats go in,
// and every beat gives one status and the new entry count. A software copy
// of the list, kept as a queue in insertion order, predicts each result at
// the moment its input beat is accepted. The monitor checks results in
// order against those predictions.
module tb;

    import olarm_pkg::*;

    localparam int CAPACITY    = 16;
    localparam int POOL_N      = 8;
    localparam int PHASE_ITEMS = 200;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_PRINTS  = 20;

    typedef struct packed {
        logic                     act;
        logic signed [DATA_W-1:0] val;
    } list_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] st;
        logic [COUNT_W-1:0]  cnt;
    } list_result_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic                     action;
    logic signed [DATA_W-1:0] item_value;
    logic                     out_valid;
    logic                     out_stall;
    logic [STATUS_W-1:0]      status;
    logic [COUNT_W-1:0]       entry_count;

    // Beats waiting to be driven, the predicted results in arrival order,
    // and the software copy of the list with the oldest entry in front.
    list_item_t               item_queue[$];
    list_result_t             predicted_results[$];
    logic signed [DATA_W-1:0] list_entries[$];
    logic signed [DATA_W-1:0] value_pool[POOL_N];

    int  send_idle_pct;
    int  recv_idle_pct;
    int  mismatch_count;
    int  cycle_count;
    int  status_tally[4];
    int  results_seen;
    int  peak_count;
    logic in_took;

    ordered_list_append_remove_match #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .item_value (item_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .entry_count(entry_count)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Applies one item to the software list and returns the status and
    // count that the block must report for it. An append to a full list
    // leaves the list alone; a remove takes out only the oldest entry whose
    // bit pattern matches, and the entries behind it close up in order.
    function automatic list_result_t apply_list_op(list_item_t it);
        list_result_t r;
        int           hit;
        hit = -1;
        if (it.act == ACT_APPEND)
        begin
            if (list_entries.size() >= CAPACITY)
            begin
                r.st = ST_FULL;
            end
            else
            begin
                list_entries.push_back(it.val);
                r.st = ST_APPENDED;
            end
        end
        else
        begin
            for (int i = 0; i < list_entries.size(); i++)
            begin
                if (hit < 0 && list_entries[i] === it.val)
                begin
                    hit = i;
                end
            end
            if (hit >= 0)
            begin
                list_entries.delete(hit);
                r.st = ST_REMOVED;
            end
            else
            begin
                r.st = ST_NOT_FOUND;
            end
        end
        r.cnt = COUNT_W'(list_entries.size());
        return r;
    endfunction

    // Prints one line per mismatch, up to a cap, and counts every one.
    task automatic report_mismatch(string what);
        if (mismatch_count < MAX_PRINTS)
        begin
            $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        end
        mismatch_count++;
    endtask

    task automatic queue_item(logic act, logic signed [DATA_W-1:0] val);
        list_item_t it;
        it.act = act;
        it.val = val;
        item_queue.push_back(it);
    endtask

    // Random traffic comes in bursts. A fill burst is mostly appends and
    // drives the list up to full; a drain burst is mostly removes and walks
    // it back down. Most values come from a small pool so that removes
    // find matches and duplicates pile up; the rest are full-width random
    // values, which also give the not-found case on removes.
    task automatic queue_random_items(int n);
        int         left;
        int         burst;
        int         fill;
        list_item_t it;
        left = n;
        while (left > 0)
        begin
            burst = $urandom_range(24, 6);
            fill  = $urandom_range(1);
            for (int k = 0; k < burst && left > 0; k++)
            begin
                it.act = ($urandom_range(99) < (fill ? 20 : 80)) ? ACT_REMOVE : ACT_APPEND;
                if ($urandom_range(99) < 75)
                begin
                    it.val = value_pool[$urandom_range(POOL_N - 1)];
                end
                else
                begin
                    it.val = $urandom();
                end
                item_queue.push_back(it);
                left--;
            end
        end
    endtask

    task automatic wait_queue_drained();
        while (item_queue.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Driver. Inputs change on the falling edge only. A beat stays on the
    // wires until the rising edge that accepted it; after that the next
    // beat goes out, unless the sender decides to idle this cycle. Only one
    // assignment to in_valid happens per edge, so a held beat never drops.
    always @(negedge clk)
    begin : drive_inputs
        list_item_t nx;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_took)
        begin
            if (item_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nx = item_queue.pop_front();
                in_valid   <= 1'b1;
                action     <= nx.act;
                item_value <= nx.val;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Input side of the checker: every accepted beat is run through the
    // software list right away, so predictions line up with acceptance.
    always @(posedge clk)
    begin : predict_results
        list_item_t   it;
        list_result_t r;
        in_took <= in_valid && !in_stall;
        if (in_valid && !in_stall)
        begin
            it.act = action;
            it.val = item_value;
            r = apply_list_op(it);
            predicted_results.push_back(r);
            status_tally[r.st]++;
            if (r.cnt > peak_count)
            begin
                peak_count = r.cnt;
            end
        end
    end

    // Monitor: each accepted result beat is matched against the oldest
    // prediction, field by field.
    always @(posedge clk)
    begin : check_results
        list_result_t exp_r;
        if (out_valid && !out_stall)
        begin
            results_seen++;
            if (predicted_results.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing expected: status %0d count %0d",
                                          status, entry_count));
            end
            else
            begin
                exp_r = predicted_results.pop_front();
                if (status !== exp_r.st)
                begin
                    report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                              results_seen, status, exp_r.st));
                end
                if (entry_count !== exp_r.cnt)
                begin
                    report_mismatch($sformatf("result %0d count %0d, expected %0d",
                                              results_seen, entry_count, exp_r.cnt));
                end
            end
        end
    end

    // Watchdog. CYCLE_LIMIT lies well beyond any correct run, even with
    // heavy stalls, so this limit only trips on a hang.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timed out with %0d beats unsent and %0d results outstanding.",
                     item_queue.size(), predicted_results.size());
            $display("[ordered_list_append_remove_match] ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        action         = ACT_APPEND;
        item_value     = '0;
        out_stall      = 1'b0;
        in_took        = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        results_seen   = 0;
        peak_count     = 0;
        status_tally   = '{default: 0};
        send_idle_pct  = 20;
        recv_idle_pct  = 62;

        // The pool mixes the extreme patterns with four random words.
        value_pool[0] = 32'sh7FFF_FFFF;
        value_pool[1] = 32'sh8000_0000;
        value_pool[2] = '0;
        value_pool[3] = '1;
        for (int i = 4; i < POOL_N; i++)
        begin
            value_pool[i] = $urandom();
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed opening. A remove on the empty list reports not found.
        queue_item(ACT_REMOVE, 32'sd5);
        // Extreme values and alternating bit patterns, with a duplicate pair.
        queue_item(ACT_APPEND, 32'sh7FFF_FFFF);
        queue_item(ACT_APPEND, 32'sh8000_0000);
        queue_item(ACT_APPEND, 32'sh0000_0000);
        queue_item(ACT_APPEND, 32'shFFFF_FFFF);
        queue_item(ACT_APPEND, 32'sd7);
        queue_item(ACT_APPEND, 32'sd7);
        queue_item(ACT_APPEND, 32'sh5555_5555);
        queue_item(ACT_APPEND, 32'shAAAA_AAAA);
        // Only the older of the two sevens goes; then a middle entry goes,
        // then a value that is not held at all.
        queue_item(ACT_REMOVE, 32'sd7);
        queue_item(ACT_REMOVE, 32'sh8000_0000);
        queue_item(ACT_REMOVE, 32'sd12345);
        // Fill up to capacity, then try one append too many.
        for (int i = 1; i <= 10; i++)
        begin
            queue_item(ACT_APPEND, 32'(i * 32'sh0101_0101));
        end
        queue_item(ACT_APPEND, 32'sd99);
        // Remove the head of a full list, refill, and remove the tail.
        queue_item(ACT_REMOVE, 32'sh7FFF_FFFF);
        queue_item(ACT_APPEND, 32'sd42);
        queue_item(ACT_REMOVE, 32'sd42);

        // Phase one: sender idles lightly, receiver stalls heavily.
        queue_random_items(PHASE_ITEMS);
        wait_queue_drained();

        // Phase two: the other way round.
        send_idle_pct = 62;
        recv_idle_pct = 20;
        queue_random_items(PHASE_ITEMS);
        wait_queue_drained();

        // Phase three: back-to-back traffic with no idling on either side.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_items(PHASE_ITEMS);
        wait_queue_drained();

        // Let the last beat be taken and every result come out, then keep
        // watching the output so that any stray result shows.
        while (in_valid || predicted_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        if (predicted_results.size() != 0)
        begin
            report_mismatch($sformatf("%0d results never arrived", predicted_results.size()));
        end

        $display("Checked %0d results: %0d appended, %0d removed, %0d not found, %0d full.",
                 results_seen, status_tally[ST_APPENDED], status_tally[ST_REMOVED],
                 status_tally[ST_NOT_FOUND], status_tally[ST_FULL]);
        $display("Peak list length %0d of %0d, %0d mismatches, three stall profiles.",
                 peak_count, CAPACITY, mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("[ordered_list_append_remove_match] OK");
        end
        else
        begin
            $display("[ordered_list_append_remove_match] ERROR");
        end
        $finish;
    end

endmodule
